### sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// shared types and constants for the sorted list engine
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;
  localparam int POS_W     = 4;
  localparam int OCC_W     = 5;
  localparam int M_DATA_W  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_COUNT  = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_e;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic go;
    logic found;
  } wave_t;

endpackage

### sv/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell
// one slot of the sorted row: holds an entry, compares it with the key and
// passes the match wave and shifted entries to its neighbours
// ----------------------------------------------------------------------------
module sle_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int CAPACITY    = 16,
  parameter int IDX         = 0,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CW-1:0]          fill,
  input  logic [VALUE_WIDTH-1:0] key,
  input  sle_pkg::cell_op_e      op,
  input  logic [VALUE_WIDTH-1:0] left_entry,
  input  logic [VALUE_WIDTH-1:0] right_entry,
  input  logic                   left_ge,
  output logic [VALUE_WIDTH-1:0] entry,
  output logic                   ge,
  input  sle_pkg::wave_t         wave_in,
  input  logic [CW-1:0]          cnt_in,
  input  logic [IW-1:0]          pos_in,
  output sle_pkg::wave_t         wave_out,
  output logic [CW-1:0]          cnt_out,
  output logic [IW-1:0]          pos_out
);
  import sle_pkg::*;

  logic valid;
  logic hit;
  logic go;
  logic found;
  logic past;

  assign valid = CW'(IDX) < fill;
  assign hit   = valid && (entry == key);
  assign ge    = !valid || (entry >= key);

  assign wave_out = '{go: go, found: found};

  always_ff @(posedge clk) begin
    if (rst) begin
      go   <= 1'b0;
      past <= 1'b0;
    end else begin
      go <= wave_in.go;
      if (wave_in.go) begin
        past <= wave_in.found || hit;
      end
    end
    if (wave_in.go) begin
      found   <= wave_in.found || hit;
      cnt_out <= cnt_in + CW'(hit);
      pos_out <= wave_in.found ? pos_in : IW'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_INSERT: begin
        if (left_ge) begin
          entry <= left_entry;
        end else if (ge) begin
          entry <= key;
        end
      end
      OP_REMOVE: begin
        if (past) begin
          entry <= right_entry;
        end
      end
      default: begin
        entry <= entry;
      end
    endcase
  end

endmodule

### sv/sle_row.sv
// ----------------------------------------------------------------------------
// sle_row
// chain of list cells: the match wave runs one cell per cycle, entries shift
// by one cell on insert or remove
// ----------------------------------------------------------------------------
module sle_row #(
  parameter int VALUE_WIDTH = 32,
  parameter int CAPACITY    = 16,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int IW = $clog2(CAPACITY)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [CW-1:0]          fill,
  input  logic [VALUE_WIDTH-1:0] key,
  input  sle_pkg::cell_op_e      op,
  output sle_pkg::wave_t         wave_last,
  output logic [CW-1:0]          cnt_last,
  output logic [IW-1:0]          pos_last
);
  import sle_pkg::*;

  logic [VALUE_WIDTH-1:0] entries [CAPACITY];
  logic                   ges     [CAPACITY];
  wave_t                  waves   [CAPACITY+1];
  logic [CW-1:0]          cnts    [CAPACITY+1];
  logic [IW-1:0]          poss    [CAPACITY+1];

  assign waves[0] = '{go: start, found: 1'b0};
  assign cnts[0]  = '0;
  assign poss[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_entry;
    logic [VALUE_WIDTH-1:0] right_entry;
    logic                   left_ge;

    if (i == 0) begin : g_first
      assign left_entry = entries[i];
      assign left_ge    = 1'b0;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_ge    = ges[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    sle_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CAPACITY    (CAPACITY),
      .IDX         (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .fill        (fill),
      .key         (key),
      .op          (op),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .left_ge     (left_ge),
      .entry       (entries[i]),
      .ge          (ges[i]),
      .wave_in     (waves[i]),
      .cnt_in      (cnts[i]),
      .pos_in      (poss[i]),
      .wave_out    (waves[i+1]),
      .cnt_out     (cnts[i+1]),
      .pos_out     (poss[i+1])
    );
  end

  assign wave_last = waves[CAPACITY];
  assign cnt_last  = cnts[CAPACITY];
  assign pos_last  = poss[CAPACITY];

endmodule

### sv/sorted_list_engine.sv
// ----------------------------------------------------------------------------
// sorted_list_engine
// bounded multiset of signed values in ascending order, held in a row of
// cells; insert, remove first match, count matches, search first match
// ----------------------------------------------------------------------------
// channel  dir  item
// s_axis   in   tuser: cmd; tdata: value
// m_axis   out  tdata: status, match_count, position, occupancy
//
// one item at a time: the compare wave walks the cell row one cell per cycle,
// then SCAN collects the match result and APPLY updates the row and
// registers the result
// the result register frees the input side while a result waits to be taken
// rst clears the fill count and control; stored entries need no clearing
// a stalled output holds the engine in its update step, row unchanged
// ----------------------------------------------------------------------------
module sorted_list_engine #(
  parameter int CAPACITY    = sle_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = sle_pkg::VALUE_WIDTH_DEF,
  localparam int S_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [S_DATA_W-1:0]          s_tdata,   // value
  input  logic [sle_pkg::CMD_W-1:0]    s_tuser,   // cmd
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sle_pkg::M_DATA_W-1:0] m_tdata    // status, match_count, position, occupancy
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic [VALUE_WIDTH-1:0] SIGN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    APPLY
  } state_t;

  state_t                 state;
  cmd_e                   cmd;
  logic [VALUE_WIDTH-1:0] key;
  logic                   start;
  logic [CW-1:0]          fill;
  logic [CW-1:0]          fill_next;
  logic                   res_found;
  logic [CW-1:0]          res_cnt;
  logic [IW-1:0]          res_pos;
  wave_t                  wave_last;
  logic [CW-1:0]          cnt_last;
  logic [IW-1:0]          pos_last;
  cell_op_e               op;
  logic                   out_free;
  logic                   full;
  logic [STATUS_W-1:0]    status;
  logic [COUNT_W-1:0]     match_count;
  logic [POS_W-1:0]       position;

  assign s_tready = (state == IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign full     = (fill == CW'(CAPACITY));

  always_comb begin
    status      = ST_DONE;
    match_count = '0;
    position    = '0;
    fill_next   = fill;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          fill_next = fill + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (res_found) begin
          fill_next = fill - 1'b1;
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      CMD_COUNT: begin
        match_count = COUNT_W'(res_cnt);
      end
      default: begin
        if (res_found) begin
          position = POS_W'(res_pos);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_comb begin
    op = OP_HOLD;
    if (state == APPLY && out_free) begin
      if (cmd == CMD_INSERT && !full) begin
        op = OP_INSERT;
      end else if (cmd == CMD_REMOVE && res_found) begin
        op = OP_REMOVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      start    <= 1'b0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      start <= (state == IDLE) && s_tvalid;
      if (state == APPLY && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (wave_last.go) begin
            state <= APPLY;
          end
        end
        APPLY: begin
          if (out_free) begin
            fill  <= fill_next;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
    if (state == IDLE && s_tvalid) begin
      cmd <= cmd_e'(s_tuser);
      key <= s_tdata[VALUE_WIDTH-1:0] ^ SIGN;
    end
    if (state == SCAN && wave_last.go) begin
      res_found <= wave_last.found;
      res_cnt   <= cnt_last;
      res_pos   <= pos_last;
    end
    if (state == APPLY && out_free) begin
      m_tdata <= {OCC_W'(fill_next), position, match_count, status};
    end
  end

  sle_row #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .CAPACITY    (CAPACITY)
  ) u_row (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .fill      (fill),
    .key       (key),
    .op        (op),
    .wave_last (wave_last),
    .cnt_last  (cnt_last),
    .pos_last  (pos_last)
  );

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_wave_in_scan: assert property (@(posedge clk) disable iff (rst)
    wave_last.go |-> state == SCAN)
    else $error("match wave finished outside scan");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    op == OP_INSERT |=> fill == CW'($past(fill) + 1'b1))
    else $error("insert did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    op == OP_REMOVE |=> fill == CW'($past(fill) - 1'b1))
    else $error("remove did not shrink the list");
`endif

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for sorted_list_engine: commands go in on the input
// stream with random gaps, a shadow sorted list predicts every result, and
// each result taken from the output stream (under random backpressure) is
// checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb;
  import sle_pkg::*;

  localparam int LIST_DEPTH  = CAPACITY_DEF;
  localparam int DRAIN_WAIT  = 2 * (CAPACITY_DEF + 3) + 10;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  match_count;
    logic [POS_W-1:0]    position;
    logic [OCC_W-1:0]    occupancy;
  } list_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;           // value
  logic [CMD_W-1:0] s_tuser = CMD_INSERT; // cmd
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;        // status, match_count, position, occupancy

  // shadow copy of the sorted list
  logic signed [31:0] list_vals [LIST_DEPTH];
  int list_fill = 0;

  list_result_t pending_results [$];
  logic signed [31:0] value_pool [6];

  bit quiet = 1'b0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int full_rejects = 0;
  int misses = 0;
  int peak_fill = 0;

  sorted_list_engine dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("sorted_list_engine verification failed");
      $finish;
    end
  end

  // works out the result of one command and updates the shadow list
  function automatic list_result_t apply_list_cmd(input cmd_e cmd,
                                                  input logic signed [31:0] v);
    list_result_t r;
    int at;
    int hits;
    r.status = ST_DONE;
    r.match_count = '0;
    r.position = '0;
    at = 0;
    hits = 0;
    case (cmd)
      CMD_INSERT: begin
        if (list_fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
          full_rejects++;
        end else begin
          while (at < list_fill && list_vals[at] < v) at++;
          for (int i = list_fill; i > at; i--) list_vals[i] = list_vals[i-1];
          list_vals[at] = v;
          list_fill++;
        end
      end
      CMD_REMOVE: begin
        while (at < list_fill && list_vals[at] != v) at++;
        if (at >= list_fill) begin
          r.status = ST_NOT_FOUND;
          misses++;
        end else begin
          for (int i = at; i + 1 < list_fill; i++) list_vals[i] = list_vals[i+1];
          list_fill--;
        end
      end
      CMD_COUNT: begin
        for (int i = 0; i < list_fill; i++)
          if (list_vals[i] == v) hits++;
        r.match_count = hits[COUNT_W-1:0];
      end
      default: begin
        while (at < list_fill && list_vals[at] != v) at++;
        if (at >= list_fill) begin
          r.status = ST_NOT_FOUND;
          misses++;
        end else begin
          r.position = at[POS_W-1:0];
        end
      end
    endcase
    r.occupancy = list_fill[OCC_W-1:0];
    if (list_fill > peak_fill) peak_fill = list_fill;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(input cmd_e cmd, input logic [31:0] value);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(apply_list_cmd(cmd, value));
    items_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item, m_tdata", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_tdata[1:0] != want.status)
          report_mismatch("status", m_tdata[1:0], want.status);
        if (m_tdata[6:2] != want.match_count)
          report_mismatch("match_count", m_tdata[6:2], want.match_count);
        if (m_tdata[10:7] != want.position)
          report_mismatch("position", m_tdata[10:7], want.position);
        if (m_tdata[15:11] != want.occupancy)
          report_mismatch("occupancy", m_tdata[15:11], want.occupancy);
      end
    end
  end

  // output backpressure in short bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      hold_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic test_empty_list();
    send_item(CMD_SEARCH, 32'd5);
    send_item(CMD_REMOVE, 32'd5);
    send_item(CMD_COUNT, 32'd5);
  endtask

  task automatic test_extremes_and_duplicates();
    send_item(CMD_INSERT, 32'h7fff_ffff);
    send_item(CMD_INSERT, 32'h8000_0000);
    send_item(CMD_INSERT, 32'd0);
    send_item(CMD_INSERT, 32'hffff_ffff);
    send_item(CMD_INSERT, 32'd0);
    send_item(CMD_COUNT, 32'd0);
    send_item(CMD_SEARCH, 32'd0);
    send_item(CMD_SEARCH, 32'h7fff_ffff);
    send_item(CMD_SEARCH, 32'h8000_0000);
    send_item(CMD_REMOVE, 32'd0);
    send_item(CMD_COUNT, 32'd0);
    send_item(CMD_REMOVE, 32'd3);
    send_item(CMD_SEARCH, 32'd3);
  endtask

  // empties the list, fills it with one value and pushes past full
  task automatic test_full_store();
    send_item(CMD_REMOVE, 32'h7fff_ffff);
    send_item(CMD_REMOVE, 32'h8000_0000);
    send_item(CMD_REMOVE, 32'd0);
    send_item(CMD_REMOVE, 32'hffff_ffff);
    repeat (LIST_DEPTH) send_item(CMD_INSERT, 32'd42);
    send_item(CMD_COUNT, 32'd42);
    send_item(CMD_INSERT, 32'hffff_fff0);
    send_item(CMD_SEARCH, 32'd42);
  endtask

  task automatic refill_pool();
    foreach (value_pool[i])
      value_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 6) - 3;
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    return value_pool[$urandom_range(0, 5)];
  endfunction

  task automatic test_random_mix(input int n, input int insert_pct, input int remove_pct);
    int r;
    cmd_e cmd;
    refill_pool();
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) cmd = CMD_INSERT;
      else if (r < insert_pct + remove_pct) cmd = CMD_REMOVE;
      else if (r[0]) cmd = CMD_COUNT;
      else cmd = CMD_SEARCH;
      if (k % 50 == 49) refill_pool();
      send_item(cmd, pick_value());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_extremes_and_duplicates();
    test_full_store();
    test_random_mix(200, 35, 35);
    test_random_mix(200, 60, 20);
    test_random_mix(200, 15, 60);
    quiet = 1'b1;
    test_random_mix(200, 40, 35);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("%0d commands sent, %0d results checked, peak occupancy %0d",
             items_sent, results_checked, peak_fill);
    $display("%0d inserts rejected as full, %0d lookups or removals with no match",
             full_rejects, misses);
    if (mismatches == 0) begin
      $display("sorted_list_engine verification clean");
    end else begin
      $display("sorted_list_engine verification failed");
    end
    $finish;
  end

endmodule

### files.f
sv/sle_pkg.sv
sv/sle_cell.sv
sv/sle_row.sv
sv/sorted_list_engine.sv
dv/tb.sv
